@@ rtl/ssa_pkg.sv @@
// Shared types and constants for the sector space allocator.
// Used by the controller, the datapath, the top level and the checker; depends on nothing.
package ssa_pkg;

    localparam int ADDR_BITS  = 32;                 // write pointer width, 16..32
    localparam int ADDR_OUT_W = 32;                 // block_address field width
    localparam int SIZE_W     = 16;                 // block_size and free space width
    localparam int LOG2_W     = 4;                  // page_size_log2 register width
    localparam int PCT_W      = 7;                  // fill_percent width
    localparam int COST_W     = SIZE_W + 2;         // header plus aligned block
    localparam int TOT_W      = ADDR_BITS + 1;      // used plus free
    localparam int DIVD_W     = ADDR_BITS + PCT_W;  // used times 100
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_STEPS  = PCT_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [5:0]          HDR_BYTES   = 6'd32;
    localparam logic [PCT_W-1:0]    PCT_SCALE   = 7'd100;
    localparam logic [LOG2_W-1:0]   RST_LOG2    = 4'd5;
    localparam logic [CFG_W-1:0]    RST_BASE    = 32'd0;
    localparam logic [SIZE_W-1:0]   RST_CAP     = 16'd65504;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_OPEN  = 1'b1;

    localparam int IN_DATA_W  = 16;   // block_size
    localparam int OUT_DATA_W = 56;   // block_address, free_bytes, fill_percent, pad

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;    // capture the accepted request
        logic update;     // apply open or allocation to the sector state
        logic calc_used;  // compute used space from the new pointer
        logic mult;       // form used*100 and the divisor
        logic div_step;   // one restoring division step
        logic load_out;   // move the result into the output register
    } ssa_cmd_t;

endpackage

@@ rtl/ssa_ctrl.sv @@
// Controller state machine of the sector space allocator.
// Sequences one request through the datapath; uses ssa_pkg.
module ssa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output ssa_pkg::ssa_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_USED,
        ST_MULT,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t                      state_reg, state_next;
    logic [ssa_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        valid_reg, valid_next;
    logic                        out_free;

    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !m_tready;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_USED;
            end
            ST_USED: begin
                cmd.calc_used = 1'b1;
                state_next    = ST_MULT;
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == ssa_pkg::CNT_W'(ssa_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

@@ rtl/ssa_datapath.sv @@
// Datapath of the sector space allocator: configuration registers, sector state,
// cost check, used-space multiply, restoring divider and output register; uses ssa_pkg.
module ssa_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ssa_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [ssa_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic [ssa_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                s_tuser,
    input  ssa_pkg::ssa_cmd_t                   cmd,
    output logic [ssa_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tuser
);

    localparam int AB     = ssa_pkg::ADDR_BITS;
    localparam int SW     = ssa_pkg::SIZE_W;
    localparam int CW     = ssa_pkg::COST_W;
    localparam int TW     = ssa_pkg::TOT_W;
    localparam int DW     = ssa_pkg::DIVD_W;
    localparam int PW     = ssa_pkg::PCT_W;

    // Configuration registers.
    logic [ssa_pkg::LOG2_W-1:0] log2_reg;
    logic [ssa_pkg::CFG_W-1:0]  base_reg;
    logic [SW-1:0]              cap_reg;

    // Sector state.
    logic [AB-1:0] wp_reg, wp_next;
    logic [SW-1:0] free_reg, free_next;

    // Request and working registers.
    logic          op_reg;
    logic [SW-1:0] size_reg;
    logic          granted_reg;
    logic [AB-1:0] addr_reg;
    logic [AB-1:0] used_reg;
    logic          tot_zero_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [PW-1:0] quo_reg;

    logic [ssa_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                           out_user_reg;

    // Cost of an allocation: header plus size rounded up to the page.
    logic [CW-1:0] page_m1;
    logic [CW-1:0] aligned;
    logic [CW-1:0] cost;
    logic          fits;
    logic [AB-1:0] base_trunc;
    logic [TW-1:0] total;
    logic [DW-1:0] rem_diff;
    logic          rem_ge;
    logic [PW-1:0] fill;

    assign base_trunc = base_reg[AB-1:0];
    assign page_m1 = (CW'(1) << log2_reg) - CW'(1);
    assign aligned = (CW'(size_reg) + page_m1) & ~page_m1;
    assign cost    = CW'(ssa_pkg::HDR_BYTES) + aligned;
    assign fits    = CW'(free_reg) >= cost;

    assign total    = TW'(used_reg) + TW'(free_reg);
    assign rem_diff = rem_reg - dvs_reg;
    assign rem_ge   = rem_reg >= dvs_reg;
    assign fill     = tot_zero_reg ? '0 : quo_reg;

    always_comb begin
        wp_next   = wp_reg;
        free_next = free_reg;
        if (op_reg == ssa_pkg::OP_OPEN) begin
            wp_next   = base_trunc + AB'(ssa_pkg::HDR_BYTES);
            free_next = cap_reg;
        end else if (fits) begin
            wp_next   = wp_reg + AB'(cost);
            free_next = SW'(CW'(free_reg) - cost);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log2_reg <= ssa_pkg::RST_LOG2;
            base_reg <= ssa_pkg::RST_BASE;
            cap_reg  <= ssa_pkg::RST_CAP;
            wp_reg   <= ssa_pkg::RST_BASE[AB-1:0] + AB'(ssa_pkg::HDR_BYTES);
            free_reg <= ssa_pkg::RST_CAP;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    ssa_pkg::CFG_PAGE_LOG2: log2_reg <= cfg_wdata[ssa_pkg::LOG2_W-1:0];
                    ssa_pkg::CFG_BASE:      base_reg <= cfg_wdata;
                    ssa_pkg::CFG_CAPACITY:  cap_reg  <= cfg_wdata[SW-1:0];
                    default: ;
                endcase
            end
            if (cmd.update) begin
                wp_reg   <= wp_next;
                free_reg <= free_next;
            end
        end
    end

    // Payload and working registers need no reset.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= s_tuser;
            size_reg <= s_tdata[SW-1:0];
        end
        if (cmd.update) begin
            granted_reg <= (op_reg == ssa_pkg::OP_ALLOC) && fits;
            addr_reg    <= wp_reg;
        end
        if (cmd.calc_used) begin
            used_reg <= wp_reg - base_trunc - AB'(ssa_pkg::HDR_BYTES);
        end
        if (cmd.mult) begin
            rem_reg      <= DW'(used_reg) * DW'(ssa_pkg::PCT_SCALE);
            // The quotient is below 128, so the divisor starts six places up.
            dvs_reg      <= DW'(total) << (PW - 1);
            tot_zero_reg <= (total == '0);
            quo_reg      <= '0;
        end
        if (cmd.div_step) begin
            if (rem_ge) begin
                rem_reg <= rem_diff;
            end
            quo_reg <= {quo_reg[PW-2:0], rem_ge};
            dvs_reg <= dvs_reg >> 1;
        end
        if (cmd.load_out) begin
            out_user_reg <= granted_reg;
            out_data_reg <= {1'b0, fill, free_reg,
                             granted_reg ? ssa_pkg::ADDR_OUT_W'(addr_reg) : '0};
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

endmodule

@@ rtl/sector_space_allocator.sv @@
// Top level of the sector space allocator: request and result streams, config port.
// Instantiates ssa_ctrl and ssa_datapath; uses ssa_pkg.
//
// Each request either opens the flash sector (tuser 1) or allocates a block of
// s_tdata bytes (tuser 0), costing a 32-byte header plus the size rounded up to
// the page size. One request is handled at a time. After a request is accepted,
// the controller runs the state update, used-space and multiply steps, then the
// bit-per-cycle restoring divider that forms the fill percentage, and then loads
// the result into the output register, waiting while an earlier result is still
// held there by m_tready. The controller then returns to idle, and the next request
// is accepted once that result is loaded, even while it still waits for
// m_tready. Configuration writes take effect at once and should only be issued
// while no request is in flight.
module sector_space_allocator (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port.
    input  logic                               cfg_wr_en,
    input  logic [ssa_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [ssa_pkg::CFG_W-1:0]          cfg_wdata,
    // Request channel.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ssa_pkg::IN_DATA_W-1:0]      s_tdata,   // [15:0] block_size
    input  logic                               s_tuser,   // [0] opcode
    // Result channel.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] block_address, [47:32] free_bytes, [54:48] fill_percent, [55] zero
    output logic [ssa_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tuser    // [0] granted
);

    ssa_pkg::ssa_cmd_t cmd;

    ssa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ssa_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ rtl/ssa_checker.sv @@
// Port-level checks for the sector space allocator, bound to the top level.
// Sees only the top-level ports; uses ssa_pkg.
module ssa_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ssa_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                            m_tuser
);

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A refused or opening request reports address zero.
    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[31:0] == 32'd0)
        else $error("nonzero address without a grant");

    // The fill percentage never exceeds one hundred.
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[54:48] <= ssa_pkg::PCT_SCALE)
        else $error("fill percentage out of range");

    // Only one request is in flight at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in flight");

endmodule

bind sector_space_allocator ssa_checker u_ssa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
